>>> design/dtd_pkg.sv
// shared types, constants and helper functions for the date to day number block
package dtd_pkg;

	localparam int unsigned DAY_W         = 5;
	localparam int unsigned MONTH_W       = 4;
	localparam int unsigned YEAR_W        = 12;
	localparam int unsigned DAYNUM_W      = 16;
	localparam int unsigned WEEKDAY_W     = 3;
	localparam int unsigned DIFF_W        = 17;

	localparam int unsigned BASE_YEAR     = 2000;
	localparam int unsigned YEAR_SPAN_DEF = 128;
	localparam int unsigned MONTHS        = 12;
	localparam int unsigned FEBRUARY      = 2;
	localparam int unsigned DAYS_PER_YEAR = 365;

	// ceil(x/100) = floor((x+99)/100), ceil(x/400) = floor(((x+399)>>2)/100)
	localparam int unsigned CEIL100_ADD   = 99;
	localparam int unsigned CEIL400_ADD   = 399;
	localparam int unsigned CEIL4_ADD     = 3;
	localparam int unsigned CENTURY       = 100;
	localparam int unsigned QUAD_CENTURY  = 400;

	// floor(x/100) = (x*1311)>>17, exact for x below 4096
	localparam int unsigned RECIP100      = 1311;
	localparam int unsigned RECIP_SH      = 17;
	localparam int unsigned MUL_K_W       = 11;
	localparam int unsigned PROD_W        = YEAR_W + MUL_K_W;
	localparam int unsigned CNT_W         = PROD_W - RECIP_SH;
	localparam int unsigned CHK_W         = YEAR_W + 1;
	localparam int unsigned DBM_W         = 9;
	localparam int unsigned MOD7_W        = 24;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_PREP,
		OP_DIV1,
		OP_DIV2,
		OP_SUM,
		OP_FIN
	} dtd_op_t;

	typedef struct packed {
		logic    load;
		logic    sel_b;
		dtd_op_t op;
	} dtd_cmd_t;

	function automatic logic [DBM_W-1:0] days_before(input logic [MONTH_W-1:0] month);
		logic [DBM_W-1:0] d;
		unique case (month)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	// 8 = 1 mod 7, so the octal digit sum keeps the residue
	function automatic logic [WEEKDAY_W-1:0] mod7(input logic [MOD7_W-1:0] v);
		logic [5:0] s;
		logic [3:0] t;
		s = '0;
		for (int i = 0; i < MOD7_W / 3; i++) begin
			s = s + 6'(v[3*i +: 3]);
		end
		t = 4'(s[2:0]) + 4'(s[5:3]);
		if (t >= 4'd7) begin
			t = t - 4'd7;
		end
		if (t >= 4'd7) begin
			t = t - 4'd7;
		end
		return t[WEEKDAY_W-1:0];
	endfunction

endpackage

>>> design/dtd_ctrl.sv
// controller state machine sequencing both dates through the datapath
module dtd_ctrl
	import dtd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output dtd_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_PREP = 6'b000010,
		S_DIV1 = 6'b000100,
		S_DIV2 = 6'b001000,
		S_SUM  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t state_q, state_n;
	logic   sel_b_q, sel_b_n;
	logic   out_valid_q, out_valid_n;
	logic   fin_go;

	// result register is free or being emptied this cycle
	assign fin_go = !out_valid_q || !out_stall;

	always_comb begin
		state_n   = state_q;
		sel_b_n   = sel_b_q;
		cmd.load  = 1'b0;
		cmd.sel_b = sel_b_q;
		cmd.op    = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					sel_b_n = 1'b0;
					state_n = S_PREP;
				end
			end
			S_PREP: begin
				cmd.op  = OP_PREP;
				state_n = S_DIV1;
			end
			S_DIV1: begin
				cmd.op  = OP_DIV1;
				state_n = S_DIV2;
			end
			S_DIV2: begin
				cmd.op  = OP_DIV2;
				state_n = S_SUM;
			end
			S_SUM: begin
				cmd.op = OP_SUM;
				if (sel_b_q) begin
					state_n = S_FIN;
				end else begin
					sel_b_n = 1'b1;
					state_n = S_PREP;
				end
			end
			S_FIN: begin
				if (fin_go) begin
					cmd.op  = OP_FIN;
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_comb begin
		out_valid_n = out_valid_q;
		if (out_valid_q && !out_stall) begin
			out_valid_n = 1'b0;
		end
		if (state_q == S_FIN && fin_go) begin
			out_valid_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_b_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			sel_b_q     <= sel_b_n;
			out_valid_q <= out_valid_n;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> design/dtd_datapath.sv
// datapath: input capture, leap year counts, day number sum, weekday and difference
module dtd_datapath
	import dtd_pkg::*;
#(
	parameter int unsigned YEAR_SPAN = YEAR_SPAN_DEF
) (
	input  logic                        clk,
	input  dtd_cmd_t                    cmd,
	input  logic [DAY_W-1:0]            day_a,
	input  logic [MONTH_W-1:0]          month_a,
	input  logic [YEAR_W-1:0]           year_a,
	input  logic [DAY_W-1:0]            day_b,
	input  logic [MONTH_W-1:0]          month_b,
	input  logic [YEAR_W-1:0]           year_b,
	output logic [DAYNUM_W-1:0]         day_number_a,
	output logic [WEEKDAY_W-1:0]        weekday_a,
	output logic signed [DIFF_W-1:0]    day_difference,
	output logic                        range_error
);

	localparam int unsigned YEAR_END = BASE_YEAR + YEAR_SPAN;
	localparam int unsigned NA_W     = $clog2(366 * YEAR_SPAN + 64) + 1;
	localparam int unsigned EXT_W    = (NA_W > DIFF_W) ? NA_W : DIFF_W;

	logic [DAY_W-1:0]     day_a_q, day_b_q;
	logic [MONTH_W-1:0]   month_a_q, month_b_q;
	logic [YEAR_W-1:0]    year_a_q, year_b_q;
	logic                 err_q;

	logic [YEAR_W-1:0]    off_q;
	logic [PROD_W-1:0]    p_q;
	logic [CNT_W-1:0]     c100_q, c400_q;
	logic [NA_W-1:0]      part_q;
	logic [NA_W-1:0]      na_a_q, na_b_q;

	logic [DAYNUM_W-1:0]  day_number_q;
	logic [WEEKDAY_W-1:0] weekday_q;
	logic [DIFF_W-1:0]    diff_q;
	logic                 err_out_q;

	logic [DAY_W-1:0]     day_s;
	logic [MONTH_W-1:0]   month_s;
	logic [YEAR_W-1:0]    year_s;
	logic [YEAR_W-1:0]    off_c;
	logic [YEAR_W-1:0]    c4_c;
	logic [YEAR_W-1:0]    mul_a;
	logic [MUL_K_W-1:0]   mul_k;
	logic [PROD_W-1:0]    prod;
	logic [CHK_W-1:0]     off_ext;
	logic                 leap_c;
	logic                 leap_adj;
	logic [NA_W-1:0]      na_c;
	logic signed [EXT_W-1:0] na_a_x, na_b_x, diff_x;
	logic [WEEKDAY_W-1:0] wk_c;

	function automatic logic date_ok(input logic [MONTH_W-1:0] m, input logic [YEAR_W-1:0] y);
		return (m >= MONTH_W'(1)) && (m <= MONTH_W'(MONTHS)) &&
		       (y >= YEAR_W'(BASE_YEAR)) && (y < YEAR_W'(YEAR_END));
	endfunction

	assign day_s   = cmd.sel_b ? day_b_q : day_a_q;
	assign month_s = cmd.sel_b ? month_b_q : month_a_q;
	assign year_s  = cmd.sel_b ? year_b_q : year_a_q;
	assign off_c   = year_s - YEAR_W'(BASE_YEAR);
	assign c4_c    = (off_q + YEAR_W'(CEIL4_ADD)) >> 2;

	// one shared constant multiplier: two reciprocal divides, then years times 365
	always_comb begin
		unique case (cmd.op)
			OP_PREP: begin
				mul_a = off_c + YEAR_W'(CEIL100_ADD);
				mul_k = MUL_K_W'(RECIP100);
			end
			OP_DIV1: begin
				mul_a = (off_q + YEAR_W'(CEIL400_ADD)) >> 2;
				mul_k = MUL_K_W'(RECIP100);
			end
			OP_DIV2: begin
				mul_a = off_q;
				mul_k = MUL_K_W'(DAYS_PER_YEAR);
			end
			default: begin
				mul_a = off_q;
				mul_k = MUL_K_W'(RECIP100);
			end
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_k);

	// leap when divisible by 4 and not a century, unless divisible by 400
	assign off_ext  = CHK_W'(off_q);
	assign leap_c   = (off_q[1:0] == 2'b00) &&
	                  ((CHK_W'(c100_q) * CHK_W'(CENTURY) != off_ext) ||
	                   (CHK_W'(c400_q) * CHK_W'(QUAD_CENTURY) == off_ext));
	assign leap_adj = leap_c && (month_s > MONTH_W'(FEBRUARY));
	assign na_c     = NA_W'(p_q) + part_q + NA_W'(c400_q) + NA_W'(leap_adj);

	assign na_a_x = EXT_W'($signed(na_a_q));
	assign na_b_x = EXT_W'($signed(na_b_q));
	assign diff_x = na_a_x - na_b_x;
	assign wk_c   = mod7(MOD7_W'(na_a_x + EXT_W'(7)));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			day_a_q   <= day_a;
			month_a_q <= month_a;
			year_a_q  <= year_a;
			day_b_q   <= day_b;
			month_b_q <= month_b;
			year_b_q  <= year_b;
			err_q     <= !date_ok(month_a, year_a) || !date_ok(month_b, year_b);
		end
		unique case (cmd.op)
			OP_PREP: begin
				p_q   <= prod;
				off_q <= off_c;
			end
			OP_DIV1: begin
				p_q    <= prod;
				c100_q <= CNT_W'(p_q >> RECIP_SH);
			end
			OP_DIV2: begin
				p_q    <= prod;
				c400_q <= CNT_W'(p_q >> RECIP_SH);
				part_q <= NA_W'(day_s) - NA_W'(1) + NA_W'(c4_c) - NA_W'(c100_q) +
				          NA_W'(days_before(month_s));
			end
			OP_SUM: begin
				if (cmd.sel_b) begin
					na_b_q <= na_c;
				end else begin
					na_a_q <= na_c;
				end
			end
			OP_FIN: begin
				err_out_q    <= err_q;
				day_number_q <= err_q ? '0 : na_a_x[DAYNUM_W-1:0];
				weekday_q    <= err_q ? '0 : wk_c;
				diff_q       <= err_q ? '0 : diff_x[DIFF_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign day_number_a   = day_number_q;
	assign weekday_a      = weekday_q;
	assign day_difference = diff_q;
	assign range_error    = err_out_q;

endmodule

>>> design/date_to_day_number.sv
// top level: Gregorian date to day number, weekday and day difference
// the result is loaded once both dates are done, and that load waits while an older result stalls
// one word at a time: the accept, four steps per date (three of them on
// the shared multiplier) with the two dates in turn, then the result load
// a new input word is taken while the previous result still waits on out_stall
// reset (arst_n low) clears the state machine and out_valid; data registers are not reset
module date_to_day_number
	import dtd_pkg::*;
#(
	parameter int unsigned YEAR_SPAN = YEAR_SPAN_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [DAY_W-1:0]         day_a,
	input  logic [MONTH_W-1:0]       month_a,
	input  logic [YEAR_W-1:0]        year_a,
	input  logic [DAY_W-1:0]         day_b,
	input  logic [MONTH_W-1:0]       month_b,
	input  logic [YEAR_W-1:0]        year_b,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [DAYNUM_W-1:0]      day_number_a,
	output logic [WEEKDAY_W-1:0]     weekday_a,
	output logic signed [DIFF_W-1:0] day_difference,
	output logic                     range_error
);

	dtd_cmd_t cmd;

	dtd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	dtd_datapath #(
		.YEAR_SPAN (YEAR_SPAN)
	) u_datapath (
		.clk            (clk),
		.cmd            (cmd),
		.day_a          (day_a),
		.month_a        (month_a),
		.year_a         (year_a),
		.day_b          (day_b),
		.month_b        (month_b),
		.year_b         (year_b),
		.day_number_a   (day_number_a),
		.weekday_a      (weekday_a),
		.day_difference (day_difference),
		.range_error    (range_error)
	);

endmodule

>>> design/dtd_checker.sv
// port level assertions for the date to day number block, bound to the top level
module dtd_checker
	import dtd_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic [DAY_W-1:0]         day_a,
	input logic [MONTH_W-1:0]       month_a,
	input logic [YEAR_W-1:0]        year_a,
	input logic [DAY_W-1:0]         day_b,
	input logic [MONTH_W-1:0]       month_b,
	input logic [YEAR_W-1:0]        year_b,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [DAYNUM_W-1:0]      day_number_a,
	input logic [WEEKDAY_W-1:0]     weekday_a,
	input logic signed [DIFF_W-1:0] day_difference,
	input logic                     range_error
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(day_number_a) &&
		$stable(weekday_a) && $stable(day_difference) && $stable(range_error))
		else $error("result word changed while stalled");

	// flagged dates give zero results
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> day_number_a == '0 && weekday_a == '0 &&
		day_difference == '0)
		else $error("range error with nonzero result");

	a_weekday: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> weekday_a <= WEEKDAY_W'(6))
		else $error("weekday out of range");

	// one word at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a word is in flight");

endmodule

bind date_to_day_number dtd_checker u_dtd_checker (.*);
